// ----- rtl/gcr_pkg.sv -----
// Shared constants and types for the grid ray caster.
package gcr_pkg;

  // Default sizes
  localparam int MAP_DIM_DEF        = 64;
  localparam int TILE_PIXELS_DEF    = 16;
  localparam int SCREEN_COLUMNS_DEF = 1024;

  // Field widths
  localparam int POS_W  = 22;   // Q6.16 position
  localparam int DIR_W  = 18;   // Q2.16 direction
  localparam int RD_W   = 19;   // ray direction after plane add
  localparam int DD_W   = 41;   // reciprocal incl. the infinite value
  localparam int PERP_W = 24;
  localparam int PX_W   = 10;
  localparam int CFG_W  = 22;
  localparam int CFG_AW = 3;

  localparam logic [DD_W-1:0]   INF_RECIP = DD_W'(64'd1 << 40);
  localparam logic [PERP_W-1:0] PERP_MAX  = '1;
  localparam logic [PX_W-1:0]   PX_MAX    = '1;

  // Register reset values
  localparam logic [DIR_W-1:0] DIR_X_RST   = 18'd65536;
  localparam logic [DIR_W-1:0] DIR_Y_RST   = 18'd0;
  localparam logic [DIR_W-1:0] PLANE_X_RST = 18'd0;
  localparam logic [DIR_W-1:0] PLANE_Y_RST = 18'd43254;

  // Register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_PLAYER_X  = 3'd0,
    REG_PLAYER_Y  = 3'd1,
    REG_VIEW_DX   = 3'd2,
    REG_VIEW_DY   = 3'd3,
    REG_PLANE_X   = 3'd4,
    REG_PLANE_Y   = 3'd5
  } reg_idx_t;

  // Input op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

endpackage

// ----- rtl/gcr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gcr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/grid_ray_caster_unit.sv -----
// Grid ray caster: wall map store, reciprocal divider/multiplier sequencer and DDA walk.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------------
//  in_     | in  | tvalid / tready  | tuser: op; tdata: column, cell x/y, wall
//  out_    | out | tvalid / tready  | tuser: no_hit; tdata: hit cell, side, dist, end
//  cfg_    | in  | we only          | addr: register index; wdata: value
//
// A map write to an in-range cell is stored as it is accepted. A cast runs a 33-bit
// reciprocal division for x and then y, a 17-bit shift-add multiply per side distance,
// DDA steps of a map read each (at most 2*MAP_DIM) and, on a hit, 24-bit shift-add
// multiplies for the end pixels. After reset a clearing pass zeroes the map; in_tready
// stays low meanwhile. Config writes are taken at any time; change them only while idle.
// A finished result waits in the output register; the next item may be accepted
// while it waits, and a later result stalls until the register frees.
module grid_ray_caster_unit
  import gcr_pkg::*;
#(
  parameter int MAP_DIM        = MAP_DIM_DEF,
  parameter int TILE_PIXELS    = TILE_PIXELS_DEF,
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // column[9:0], cell_x[15:10], cell_y[21:16],
                                        // cell_wall[22], zero[23]
  input  logic              in_tuser,   // op
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // hit_x[5:0], hit_y[11:6], hit_side[12],
                                        // perp_dist[36:13], end_px_x[46:37],
                                        // end_px_y[56:47], zero[63:57]
  output logic              out_tuser,  // no_hit
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int AW      = $clog2(MAP_DIM);
  localparam int DEPTH   = MAP_DIM * MAP_DIM;
  localparam int RAW     = $clog2(DEPTH);
  localparam int MW      = ((AW > 6) ? AW : 6) + 2;
  localparam int NW      = $clog2(2 * MAP_DIM + 1);
  localparam int SD_W    = DD_W + $clog2(2 * MAP_DIM) + 2;
  localparam int COL_MAX = SCREEN_COLUMNS - 1;
  localparam int ACC_W   = 58;
  localparam int SH_W    = 33;
  localparam int REM_W   = 19;

  // ceil(2^40 / SCREEN_COLUMNS): exact floor of col*2^17/SCREEN_COLUMNS after >> 23
  localparam logic [39:0] CAM_M =
    40'(((64'd1 << 40) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS));

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RDX, S_RDY, S_DDX, S_DDY, S_SDX, S_SDY,
    S_STEP, S_CHK, S_PERP, S_EX, S_EXF, S_EY, S_EYF, S_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [POS_W-1:0] player_x_r, player_y_r;
  logic [DIR_W-1:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  // Shared unit registers
  logic [ACC_W-1:0] acc_r;
  logic [SH_W-1:0]  sh_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] dv_r;
  logic [DD_W-1:0]  mc_r;
  logic [5:0]       cnt_r;

  // Cast datapath registers
  logic signed [DIR_W-1:0] cam_r;
  logic signed [RD_W-1:0]  rdx_r, rdy_r;
  logic [DD_W-1:0]         ddx_r, ddy_r;
  logic [SD_W-1:0]         sdx_r, sdy_r;
  logic signed [MW-1:0]    mx_r, my_r;
  logic                    side_r, nohit_r;
  logic [NW-1:0]           n_r;
  logic [PERP_W-1:0]       perp_r;
  logic signed [28:0]      q_r;
  logic [PX_W-1:0]         ex_r, ey_r;
  logic [RAW-1:0]          clr_addr_r;

  logic              out_valid_r, out_nohit_r;
  logic [63:0]       out_data_r;

  // Input fields
  logic       in_op, in_wall;
  logic [9:0] in_col;
  logic [5:0] in_cx, in_cy;
  assign in_op   = in_tuser;
  assign in_col  = in_tdata[9:0];
  assign in_cx   = in_tdata[15:10];
  assign in_cy   = in_tdata[21:16];
  assign in_wall = in_tdata[22];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_nohit_r;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Shared divide / multiply step
  logic [REM_W:0]   u_trial;
  logic [REM_W-1:0] u_rem;
  logic [SH_W-1:0]  u_dsh;
  logic [ACC_W-1:0] u_acc;
  logic [SH_W-1:0]  u_msh;
  always_comb begin
    u_trial = {rem_r, sh_r[SH_W-1]};
    if (u_trial >= {1'b0, dv_r}) begin
      u_rem = REM_W'(u_trial - {1'b0, dv_r});
      u_dsh = {sh_r[SH_W-2:0], 1'b1};
    end else begin
      u_rem = u_trial[REM_W-1:0];
      u_dsh = {sh_r[SH_W-2:0], 1'b0};
    end
    u_acc = {acc_r[ACC_W-2:0], 1'b0} + (sh_r[SH_W-1] ? ACC_W'(mc_r) : '0);
    u_msh = {sh_r[SH_W-2:0], 1'b0};
  end

  // Column clamp
  logic [9:0] col_c;
  always_comb begin
    if (13'(in_col) > 13'(COL_MAX)) col_c = 10'(COL_MAX);
    else                            col_c = in_col;
  end

  // Camera offset quotient by reciprocal multiply
  logic [49:0] cam_prod;
  assign cam_prod = 50'(col_c) * 50'(CAM_M);

  // Ray direction (one multiplier, used for x then y)
  logic signed [DIR_W-1:0]   rd_dir, rd_plane;
  logic signed [2*DIR_W-1:0] rd_prod;
  logic signed [RD_W-1:0]    rd_sum;
  always_comb begin
    rd_dir   = (state_r == S_RDX) ? $signed(dir_x_r) : $signed(dir_y_r);
    rd_plane = (state_r == S_RDX) ? $signed(plane_x_r) : $signed(plane_y_r);
    rd_prod  = rd_plane * cam_r;
    rd_sum   = RD_W'(rd_dir) + RD_W'(rd_prod >>> 16);
  end

  // Magnitudes
  logic [RD_W-1:0] abs_rdx, abs_rdy;
  assign abs_rdx = rdx_r[RD_W-1] ? RD_W'(-rdx_r) : rdx_r;
  assign abs_rdy = rdy_r[RD_W-1] ? RD_W'(-rdy_r) : rdy_r;

  // Distance to the next grid line
  logic [16:0] fx_dist, fy_dist;
  assign fx_dist = rdx_r[RD_W-1] ? {1'b0, player_x_r[15:0]} : 17'h10000 - 17'(player_x_r[15:0]);
  assign fy_dist = rdy_r[RD_W-1] ? {1'b0, player_y_r[15:0]} : 17'h10000 - 17'(player_y_r[15:0]);

  // DDA step
  logic                 step_x;
  logic signed [MW-1:0] mx_nxt, my_nxt;
  logic                 step_out;
  always_comb begin
    step_x = (sdx_r < sdy_r);
    mx_nxt = mx_r;
    my_nxt = my_r;
    if (step_x) mx_nxt = rdx_r[RD_W-1] ? mx_r - MW'(1) : mx_r + MW'(1);
    else        my_nxt = rdy_r[RD_W-1] ? my_r - MW'(1) : my_r + MW'(1);
    step_out = mx_nxt[MW-1] || my_nxt[MW-1] ||
               (mx_nxt >= MW'(MAP_DIM)) || (my_nxt >= MW'(MAP_DIM));
  end

  // Perpendicular distance with saturation
  logic [SD_W-1:0]   perp_raw;
  logic [PERP_W-1:0] perp_sat;
  always_comb begin
    perp_raw = side_r ? sdy_r - SD_W'(ddy_r) : sdx_r - SD_W'(ddx_r);
    perp_sat = (|perp_raw[SD_W-1:PERP_W]) ? PERP_MAX : perp_raw[PERP_W-1:0];
  end

  // Floor of signed product / 2^16
  logic        q_neg;
  logic [27:0] q_mag;
  logic signed [28:0] q_val;
  always_comb begin
    q_neg = (state_r == S_EX) ? rdx_r[RD_W-1] : rdy_r[RD_W-1];
    if (q_neg) begin
      q_mag = 28'((u_acc[42:0] + 43'd65535) >> 16);
      q_val = -$signed({1'b0, q_mag});
    end else begin
      q_mag = 28'(u_acc[42:16]);
      q_val = $signed({1'b0, q_mag});
    end
  end

  // End pixel from position plus offset
  logic [POS_W-1:0]   px_pos;
  logic signed [29:0] px_p;
  logic [35:0]        px_scaled;
  logic [PX_W-1:0]    px_val;
  always_comb begin
    px_pos    = (state_r == S_EXF) ? player_x_r : player_y_r;
    px_p      = $signed({8'b0, px_pos}) + 30'(q_r);
    px_scaled = 36'(px_p[28:0]) * 36'(TILE_PIXELS);
    if (px_p <= 0)                          px_val = '0;
    else if (|px_scaled[35:16+PX_W])        px_val = PX_MAX;
    else                                    px_val = px_scaled[16+PX_W-1:16];
  end

  // Map memory ports
  logic           ram_we, ram_wdata, ram_rdata;
  logic [RAW-1:0] ram_waddr, ram_raddr;
  logic           wr_ok;
  assign wr_ok = (9'(in_cx) < 9'(MAP_DIM)) && (9'(in_cy) < 9'(MAP_DIM));
  always_comb begin
    if (state_r == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = in_acc && (in_op == OP_WRITE) && wr_ok;
      ram_waddr = RAW'(RAW'(in_cy) * RAW'(MAP_DIM) + RAW'(in_cx));
      ram_wdata = in_wall;
    end
    ram_raddr = RAW'(RAW'(my_nxt[AW-1:0]) * RAW'(MAP_DIM) + RAW'(mx_nxt[AW-1:0]));
  end

  gcr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic player_in;
  assign player_in = (9'(player_x_r[21:16]) < 9'(MAP_DIM)) &&
                     (9'(player_y_r[21:16]) < 9'(MAP_DIM));

  logic last;
  assign last = (cnt_r == 6'd1);

  // Result register load
  logic fin_load;
  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
      dir_x_r    <= DIR_X_RST;
      dir_y_r    <= DIR_Y_RST;
      plane_x_r  <= PLANE_X_RST;
      plane_y_r  <= PLANE_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PLAYER_X: player_x_r <= cfg_wdata;
        REG_PLAYER_Y: player_y_r <= cfg_wdata;
        REG_VIEW_DX:  dir_x_r    <= cfg_wdata[DIR_W-1:0];
        REG_VIEW_DY:  dir_y_r    <= cfg_wdata[DIR_W-1:0];
        REG_PLANE_X:  plane_x_r  <= cfg_wdata[DIR_W-1:0];
        REG_PLANE_Y:  plane_y_r  <= cfg_wdata[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (fin_load)                       out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + RAW'(1);
          if (clr_addr_r == RAW'(DEPTH - 1)) state_r <= S_IDLE;
        end

        S_IDLE: begin
          if (in_acc && (in_op == OP_CAST)) begin
            cam_r   <= $signed(cam_prod[40:23] - 18'd65536);
            nohit_r <= 1'b0;
            state_r <= S_RDX;
          end
        end

        S_RDX: begin
          rdx_r   <= rd_sum;
          state_r <= S_RDY;
        end

        S_RDY: begin
          rdy_r   <= rd_sum;
          sh_r    <= SH_W'(64'd1 << 32);
          rem_r   <= '0;
          dv_r    <= abs_rdx;
          cnt_r   <= 6'(SH_W);
          state_r <= S_DDX;
        end

        S_DDX: begin
          if (last) begin
            ddx_r   <= (rdx_r == '0) ? INF_RECIP : DD_W'(u_dsh);
            sh_r    <= SH_W'(64'd1 << 32);
            rem_r   <= '0;
            dv_r    <= abs_rdy;
            cnt_r   <= 6'(SH_W);
            state_r <= S_DDY;
          end else begin
            sh_r  <= u_dsh;
            rem_r <= u_rem;
            cnt_r <= cnt_r - 6'd1;
          end
        end

        S_DDY: begin
          if (last) begin
            ddy_r   <= (rdy_r == '0) ? INF_RECIP : DD_W'(u_dsh);
            mc_r    <= ddx_r;
            acc_r   <= '0;
            sh_r    <= {fx_dist, 16'b0};
            cnt_r   <= 6'd17;
            state_r <= S_SDX;
          end else begin
            sh_r  <= u_dsh;
            rem_r <= u_rem;
            cnt_r <= cnt_r - 6'd1;
          end
        end

        S_SDX: begin
          if (last) begin
            sdx_r   <= SD_W'(u_acc[ACC_W-1:16]);
            mc_r    <= ddy_r;
            acc_r   <= '0;
            sh_r    <= {fy_dist, 16'b0};
            cnt_r   <= 6'd17;
            state_r <= S_SDY;
          end else begin
            acc_r <= u_acc;
            sh_r  <= u_msh;
            cnt_r <= cnt_r - 6'd1;
          end
        end

        S_SDY: begin
          acc_r <= u_acc;
          sh_r  <= u_msh;
          cnt_r <= cnt_r - 6'd1;
          if (last) begin
            sdy_r <= SD_W'(u_acc[ACC_W-1:16]);
            mx_r  <= MW'(player_x_r[21:16]);
            my_r  <= MW'(player_y_r[21:16]);
            n_r   <= '0;
            if (player_in) begin
              state_r <= S_STEP;
            end else begin
              nohit_r <= 1'b1;
              state_r <= S_FIN;
            end
          end
        end

        // One grid step; the map read for the new cell is issued here
        S_STEP: begin
          mx_r   <= mx_nxt;
          my_r   <= my_nxt;
          side_r <= !step_x;
          n_r    <= n_r + NW'(1);
          if (step_x) sdx_r <= sdx_r + SD_W'(ddx_r);
          else        sdy_r <= sdy_r + SD_W'(ddy_r);
          if (step_out) begin
            nohit_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_CHK;
          end
        end

        S_CHK: begin
          if (ram_rdata) begin
            perp_r  <= perp_sat;
            state_r <= S_PERP;
          end else if (n_r == NW'(2 * MAP_DIM)) begin
            nohit_r <= 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_STEP;
          end
        end

        S_PERP: begin
          mc_r    <= DD_W'(abs_rdx);
          acc_r   <= '0;
          sh_r    <= {perp_r, 9'b0};
          cnt_r   <= 6'(PERP_W);
          state_r <= S_EX;
        end

        S_EX: begin
          acc_r <= u_acc;
          sh_r  <= u_msh;
          cnt_r <= cnt_r - 6'd1;
          if (last) begin
            q_r     <= q_val;
            state_r <= S_EXF;
          end
        end

        S_EXF: begin
          ex_r    <= px_val;
          mc_r    <= DD_W'(abs_rdy);
          acc_r   <= '0;
          sh_r    <= {perp_r, 9'b0};
          cnt_r   <= 6'(PERP_W);
          state_r <= S_EY;
        end

        S_EY: begin
          acc_r <= u_acc;
          sh_r  <= u_msh;
          cnt_r <= cnt_r - 6'd1;
          if (last) begin
            q_r     <= q_val;
            state_r <= S_EYF;
          end
        end

        S_EYF: begin
          ey_r    <= px_val;
          state_r <= S_FIN;
        end

        // Load the output register once it is free
        S_FIN: begin
          if (fin_load) begin
            out_nohit_r <= nohit_r;
            if (nohit_r) out_data_r <= '0;
            else out_data_r <= {7'b0, ey_r, ex_r, perp_r, side_r, my_r[5:0], mx_r[5:0]};
            state_r <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("no-hit result carries nonzero payload");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_tready)
    else $error("input accepted during map clear");

  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> n_r <= NW'(2 * MAP_DIM))
    else $error("DDA step count past limit");

  a_rose_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_FIN)
    else $error("result raised outside finish state");

  a_chk_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> !mx_r[MW-1] && !my_r[MW-1] &&
      mx_r < MW'(MAP_DIM) && my_r < MW'(MAP_DIM))
    else $error("map read outside the grid");

endmodule
